// ----- rtl/rotlb_pkg.sv -----
`timescale 1ns / 1ps

package rotlb_pkg;

    // per-cycle control shared by every cell of the row
    typedef struct packed {
        logic start;   // a word is being inserted this cycle
        logic evict;   // full table and no hit: whole row moves down
    } cell_ctl_t;

endpackage

// ----- rtl/rotlb_cell.sv -----
`timescale 1ns / 1ps

module rotlb_cell #(
    parameter int INDEX      = 0,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5,
    parameter int PAGE_BITS  = 8,
    parameter int FRAME_BITS = 8
) (
    input  logic                  clk,
    input  rotlb_pkg::cell_ctl_t  ctl,
    input  logic [CNT_W-1:0]      count,
    input  logic [IDX_W-1:0]      tail,
    input  logic [PAGE_BITS-1:0]  page,
    input  logic [FRAME_BITS-1:0] frame,
    input  logic [PAGE_BITS-1:0]  up_page,
    input  logic [FRAME_BITS-1:0] up_frame,
    input  logic                  shift_in,
    output logic [PAGE_BITS-1:0]  page_q,
    output logic [FRAME_BITS-1:0] frame_q,
    output logic                  match,
    output logic                  shift_out
);

    localparam logic [IDX_W-1:0] MY_IDX = INDEX[IDX_W-1:0];
    localparam logic [CNT_W-1:0] MY_CNT = INDEX[CNT_W-1:0];

    logic [PAGE_BITS-1:0]  page_reg;
    logic [PAGE_BITS-1:0]  page_next;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] frame_next;
    logic                  slot_valid;
    logic                  take_new;
    logic                  take_up;

    assign slot_valid = MY_CNT < count;
    assign match      = slot_valid && (page_reg == page);
    // once a match is seen below or here, every slot up to the tail closes the gap
    assign shift_out  = shift_in || match;

    assign take_new = ctl.start && (MY_IDX == tail);
    assign take_up  = ctl.start && !take_new && (shift_out || ctl.evict) && (MY_IDX < tail);

    always_comb
    begin
        page_next  = page_reg;
        frame_next = frame_reg;
        if (take_new)
        begin
            page_next  = page;
            frame_next = frame;
        end
        else if (take_up)
        begin
            page_next  = up_page;
            frame_next = up_frame;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg  <= page_next;
        frame_reg <= frame_next;
    end

    assign page_q  = page_reg;
    assign frame_q = frame_reg;

endmodule

// ----- rtl/recency_ordered_tlb_insert_unit.sv -----
`timescale 1ns / 1ps
// recency-ordered translation table, insert side
// input channel: a word (page, frame) is taken at any rising edge with start high;
// busy is always low, so a new word may be offered in every cycle
// the table is a row of cells, slot 0 the oldest; every cell compares its page
// against the incoming one in the same cycle and either holds, takes its upper
// neighbour's pair, or takes the new pair
// result channel: done is high in the cycle after each start,
// carrying hit, evicted_valid, evicted_page, evicted_frame and entry_count
// throughput is one word per cycle; the compare chain
// through the row of cells sets the cycle time
// the receiver cannot stall, so results are never held back
// reset clears the entry count and done; slot contents are left as they are
// and are only read once written
module recency_ordered_tlb_insert_unit #(
    parameter int ENTRIES    = 16,
    parameter int PAGE_BITS  = 8,
    parameter int FRAME_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [PAGE_BITS-1:0]             page,
    input  logic [FRAME_BITS-1:0]            frame,
    output logic                             done,
    output logic                             hit,
    output logic                             evicted_valid,
    output logic [PAGE_BITS-1:0]             evicted_page,
    output logic [FRAME_BITS-1:0]            evicted_frame,
    output logic [$clog2(ENTRIES+1)-1:0]     entry_count
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = ENTRIES[CNT_W-1:0];
    localparam logic [CNT_W-1:0] LAST_CNT = FULL_CNT - 1'b1;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  done_reg;
    logic                  hit_reg;
    logic                  hit_next;
    logic                  ev_reg;
    logic                  ev_next;
    logic [PAGE_BITS-1:0]  ev_page_reg;
    logic [PAGE_BITS-1:0]  ev_page_next;
    logic [FRAME_BITS-1:0] ev_frame_reg;
    logic [FRAME_BITS-1:0] ev_frame_next;
    logic [CNT_W-1:0]      tail_wide;
    logic [IDX_W-1:0]      tail;
    logic                  full;
    rotlb_pkg::cell_ctl_t  ctl;

    logic [PAGE_BITS-1:0]  page_q   [ENTRIES];
    logic [FRAME_BITS-1:0] frame_q  [ENTRIES];
    logic [PAGE_BITS-1:0]  up_page  [ENTRIES];
    logic [FRAME_BITS-1:0] up_frame [ENTRIES];
    logic [ENTRIES-1:0]    match_vec;
    logic [ENTRIES:0]      shift_chain;

    assign busy = 1'b0;

    assign full     = count_reg == FULL_CNT;
    assign hit_next = start && (|match_vec);
    assign ev_next  = start && full && !(|match_vec);

    assign ctl.start = start;
    assign ctl.evict = ev_next;

    // slot that receives the new pair
    always_comb
    begin
        if (|match_vec)
            tail_wide = count_reg - 1'b1;
        else if (full)
            tail_wide = LAST_CNT;
        else
            tail_wide = count_reg;
    end
    assign tail = tail_wide[IDX_W-1:0];

    assign shift_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            if (g == ENTRIES - 1)
            begin : g_top
                assign up_page[g]  = '0;
                assign up_frame[g] = '0;
            end
            else
            begin : g_mid
                assign up_page[g]  = page_q[g+1];
                assign up_frame[g] = frame_q[g+1];
            end

            rotlb_cell #(
                .INDEX      (g),
                .IDX_W      (IDX_W),
                .CNT_W      (CNT_W),
                .PAGE_BITS  (PAGE_BITS),
                .FRAME_BITS (FRAME_BITS)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .count     (count_reg),
                .tail      (tail),
                .page      (page),
                .frame     (frame),
                .up_page   (up_page[g]),
                .up_frame  (up_frame[g]),
                .shift_in  (shift_chain[g]),
                .page_q    (page_q[g]),
                .frame_q   (frame_q[g]),
                .match     (match_vec[g]),
                .shift_out (shift_chain[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (start && !(|match_vec) && !full)
            count_next = count_reg + 1'b1;
    end

    assign ev_page_next  = ev_next ? page_q[0]  : '0;
    assign ev_frame_next = ev_next ? frame_q[0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        ev_reg       <= ev_next;
        ev_page_reg  <= ev_page_next;
        ev_frame_reg <= ev_frame_next;
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign evicted_valid = ev_reg;
    assign evicted_page  = ev_page_reg;
    assign evicted_frame = ev_frame_reg;
    assign entry_count   = count_reg;

`ifndef SYNTH
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("result strobe missing after an insert");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count beyond table size");

    a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted_valid) |-> (!hit && entry_count == FULL_CNT))
        else $error("eviction reported outside a full miss");

    a_hit_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (entry_count == $past(count_reg)))
        else $error("count changed on a hit");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int TBL_ENTRIES = 16;
    localparam int SLOT_W      = $clog2(TBL_ENTRIES);
    localparam int PAGE_W      = 8;
    localparam int FRAME_W     = 8;
    localparam int COUNT_W     = $clog2(TBL_ENTRIES + 1);
    localparam int RANDOM_WORDS = 1500;

    typedef struct {
        logic [PAGE_W-1:0]  page_no;
        logic [FRAME_W-1:0] frame_no;
        int                 gap;
        bit                 drain;
    } insert_word_t;

    typedef struct packed {
        logic               hit;
        logic               ev_valid;
        logic [PAGE_W-1:0]  ev_page;
        logic [FRAME_W-1:0] ev_frame;
        logic [COUNT_W-1:0] count;
    } tlb_outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [PAGE_W-1:0]  page = '0;
    logic [FRAME_W-1:0] frame = '0;
    logic done;
    logic hit;
    logic evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FRAME_W-1:0] evicted_frame;
    logic [COUNT_W-1:0] entry_count;

    insert_word_t insert_q[$];
    tlb_outcome_t outcome_q[$];

    // shadow of the table, slot 0 oldest
    logic [PAGE_W-1:0]  lru_page[TBL_ENTRIES];
    logic [FRAME_W-1:0] lru_frame[TBL_ENTRIES];
    int                 lru_count = 0;

    insert_word_t staged_word;
    bit           staged = 1'b0;
    int           idle_left = 0;
    int           mismatch_count = 0;

    recency_ordered_tlb_insert_unit #(
        .ENTRIES    (TBL_ENTRIES),
        .PAGE_BITS  (PAGE_W),
        .FRAME_BITS (FRAME_W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .page          (page),
        .frame         (frame),
        .done          (done),
        .hit           (hit),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .evicted_frame (evicted_frame),
        .entry_count   (entry_count)
    );

    always #6 clk = ~clk;

    function automatic tlb_outcome_t lru_insert(logic [PAGE_W-1:0] pg, logic [FRAME_W-1:0] fr);
        tlb_outcome_t res;
        int slot;
        int k;
        res = '0;
        slot = -1;
        for (k = 0; k < lru_count; k++)
        begin
            if (slot < 0 && lru_page[k] == pg)
                slot = k;
        end
        if (slot >= 0)
        begin
            res.hit = 1'b1;
            for (k = slot; k < lru_count - 1; k++)
            begin
                lru_page[k]  = lru_page[k + 1];
                lru_frame[k] = lru_frame[k + 1];
            end
            lru_page[lru_count - 1]  = pg;
            lru_frame[lru_count - 1] = fr;
        end
        else if (lru_count < TBL_ENTRIES)
        begin
            lru_page[lru_count]  = pg;
            lru_frame[lru_count] = fr;
            lru_count++;
        end
        else
        begin
            // full miss: oldest pair falls out
            res.ev_valid = 1'b1;
            res.ev_page  = lru_page[0];
            res.ev_frame = lru_frame[0];
            for (k = 0; k < TBL_ENTRIES - 1; k++)
            begin
                lru_page[k]  = lru_page[k + 1];
                lru_frame[k] = lru_frame[k + 1];
            end
            lru_page[TBL_ENTRIES - 1]  = pg;
            lru_frame[TBL_ENTRIES - 1] = fr;
        end
        res.count = COUNT_W'(lru_count);
        return res;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                outcome_q.push_back(lru_insert(page, frame));
            if (!(start && busy))
            begin
                if (!staged && insert_q.size() != 0)
                begin
                    staged_word = insert_q.pop_front();
                    staged = 1'b1;
                    idle_left = staged_word.gap;
                end
                if (staged && idle_left == 0 && !(staged_word.drain && outcome_q.size() != 0))
                begin
                    start <= 1'b1;
                    page  <= staged_word.page_no;
                    frame <= staged_word.frame_no;
                    staged = 1'b0;
                end
                else
                begin
                    start <= 1'b0;
                    if (staged && idle_left != 0)
                        idle_left--;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        tlb_outcome_t want;
        tlb_outcome_t got;
        if (rst_n && done)
        begin
            got = '{hit, evicted_valid, evicted_page, evicted_frame, entry_count};
            if (outcome_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: hit=%0d ev=%0d pg=%h fr=%h cnt=%0d",
                             got.hit, got.ev_valid, got.ev_page, got.ev_frame, got.count);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (got.hit !== want.hit || got.ev_valid !== want.ev_valid
                    || got.ev_page !== want.ev_page || got.ev_frame !== want.ev_frame
                    || got.count !== want.count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $write("result differs: exp hit=%0d ev=%0d pg=%h fr=%h cnt=%0d",
                               want.hit, want.ev_valid, want.ev_page, want.ev_frame,
                               want.count);
                        $display(" / got hit=%0d ev=%0d pg=%h fr=%h cnt=%0d",
                                 got.hit, got.ev_valid, got.ev_page, got.ev_frame,
                                 got.count);
                    end
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic queue_word(logic [PAGE_W-1:0] pg, logic [FRAME_W-1:0] fr, int gap, bit drain);
        insert_word_t w;
        w.page_no  = pg;
        w.frame_no = fr;
        w.gap      = gap;
        w.drain    = drain;
        insert_q.push_back(w);
    endtask

    initial
    begin
        logic [PAGE_W-1:0] recent[TBL_ENTRIES];
        logic [PAGE_W-1:0] pool_base;
        logic [PAGE_W-1:0] pg;
        int n;
        int r;
        int burst_left;
        int gap;

        // directed: growth from empty, hits in a part-filled table, fill, full behaviour
        queue_word(8'h00, 8'h00, 0, 1'b0);
        queue_word(8'hff, 8'hff, 0, 1'b0);
        queue_word(8'h00, 8'haa, 1, 1'b0);   // hit, count must not grow
        queue_word(8'h00, 8'h55, 0, 1'b0);   // hit on the newest slot
        for (n = 1; n <= 14; n++)
            queue_word(PAGE_W'(n), ~FRAME_W'(n), n % 3, 1'b0);
        queue_word(8'hff, 8'h0f, 0, 1'b0);   // hit on the oldest slot, full
        queue_word(8'h80, 8'hf0, 0, 1'b0);   // full miss, evicts
        queue_word(8'h81, 8'h0f, 0, 1'b0);
        queue_word(8'h07, 8'h77, 2, 1'b0);   // hit in the middle
        queue_word(8'h5a, 8'ha5, 0, 1'b0);

        for (n = 0; n < TBL_ENTRIES; n++)
            recent[n] = PAGE_W'($urandom_range(0, 255));
        pool_base = PAGE_W'($urandom_range(0, 255));
        burst_left = 0;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                pg = recent[SLOT_W'($urandom_range(0, TBL_ENTRIES - 1))];
            else if (r < 70)
                pg = pool_base ^ PAGE_W'($urandom_range(0, 19));
            else
                pg = PAGE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 99) == 0)
                pool_base = PAGE_W'($urandom_range(0, 255));
            recent[SLOT_W'(n % TBL_ENTRIES)] = pg;
            if (burst_left > 0)
            begin
                burst_left--;
                gap = 0;
            end
            else
            begin
                gap = pick_gap();
                if ($urandom_range(0, 49) == 0)
                    burst_left = $urandom_range(20, 60);
            end
            queue_word(pg, FRAME_W'($urandom_range(0, 255)), gap,
                       (n == 0) || ($urandom_range(0, 249) == 0));
        end

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (insert_q.size() != 0 || staged || start || outcome_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        if (mismatch_count == 0 && outcome_q.size() == 0)
            $display("recency_ordered_tlb_insert_unit: match");
        else
            $display("recency_ordered_tlb_insert_unit: mismatch");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("recency_ordered_tlb_insert_unit: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rotlb_pkg.sv
rtl/rotlb_cell.sv
rtl/recency_ordered_tlb_insert_unit.sv
test/tb.sv
